// ----- src/rtpq_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table of the rectangular to polar converter.
package rtpq_pkg;

	localparam int DATA_WIDTH_DEF   = 16;
	localparam int FRAC_BITS_DEF    = 8;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int GUARD_BITS = 28;
	localparam int ANG_FRAC   = 24;
	localparam int DEG_RIGHT  = 90;
	localparam int ATAN_LEN   = 32;
	localparam int ATAN_W     = 30;

	// atan(2^-i) in degrees, 24 fraction bits
	localparam logic [ATAN_W-1:0] ATAN_DEG [ATAN_LEN] = '{
		30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
		30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
		30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
		30'd234684,    30'd117342,    30'd58671,     30'd29335,
		30'd14668,     30'd7334,      30'd3667,      30'd1833,
		30'd917,       30'd458,       30'd229,       30'd115,
		30'd57,        30'd29,        30'd14,        30'd7,
		30'd4,         30'd2,         30'd1,         30'd0
	};

	typedef enum logic [2:0] {
		QUAD_NONE = 3'd0,
		QUAD_1    = 3'd1,
		QUAD_2    = 3'd2,
		QUAD_3    = 3'd3,
		QUAD_4    = 3'd4
	} quad_t;

endpackage

// ----- src/rect_to_polar_quadrant.sv -----
`timescale 1ns / 1ps
// Rectangular to polar converter: pipelined magnitude root and CORDIC reference angle.
//
// Input channel: sample_valid / sample_stall carry real_in and imag_in, signed integers.
// Output channel: result_valid / result_stall carry magnitude_out (sqrt(re^2+im^2)),
// angle_out (atan(|im/re|) in degrees, 0 to 90) and quadrant_out (1 to 4, 0 on an axis).
// Magnitude and angle carry FRAC_BITS fraction bits and are rounded to nearest.
// An item is moved at a rising edge with valid high and stall low.
//
// Throughput is one item per cycle while result_stall does not hold the pipe.
// The stages are absolute value, square, sum, one stage per root digit / CORDIC
// rotation running side by side, then clamp and round stages.
//
// The whole pipeline advances together whenever the output register is empty or taken;
// while result_stall holds a waiting result, every stage holds and sample_stall is high,
// so nothing is lost or repeated. Bubbles move with the items and are not squeezed out.
// Reset clears all valid bits; the first item can be accepted in the cycle after reset.
module rect_to_polar_quadrant
	import rtpq_pkg::*;
#(
	parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [DATA_WIDTH-1:0]        real_in,
	input  logic signed [DATA_WIDTH-1:0]        imag_in,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [DATA_WIDTH+FRAC_BITS-1:0]     magnitude_out,
	output logic [FRAC_BITS+6:0]                angle_out,
	output logic [2:0]                          quadrant_out
);

	localparam int MAG_W    = DATA_WIDTH + FRAC_BITS;
	localparam int ANG_W    = FRAC_BITS + 7;
	localparam int SQ_ITERS = MAG_W;
	localparam int N_W      = 2 * DATA_WIDTH;
	localparam int REM_W    = MAG_W + 2;
	localparam int ITERS    = (SQ_ITERS > CORDIC_STEPS) ? SQ_ITERS : CORDIC_STEPS;
	localparam int XW       = DATA_WIDTH + GUARD_BITS + 2;
	localparam int ZW       = 33;
	localparam int ZC_W     = 31;
	localparam int SH       = ANG_FRAC - FRAC_BITS;

	localparam logic [ZC_W-1:0]  ANGLE_TOP = ZC_W'(DEG_RIGHT) << ANG_FRAC;
	localparam logic [ZC_W:0]    ANG_HALF  = (ZC_W + 1)'(1) << (SH - 1);
	localparam logic [ANG_W-1:0] ANG_RIGHT = ANG_W'(DEG_RIGHT) << FRAC_BITS;

	logic adv;

	// stage 1
	logic                  vld_s1;
	logic [DATA_WIDTH-1:0] ar_s1, ai_s1;
	logic                  zr_s1, zi_s1;
	quad_t                 quad_s1;
	logic [DATA_WIDTH-1:0] ar_c, ai_c;
	quad_t                 quad_c;

	// stage 2
	logic                  vld_s2;
	logic [DATA_WIDTH-1:0] ar_s2, ai_s2;
	logic                  zr_s2, zi_s2;
	quad_t                 quad_s2;
	logic [N_W-1:0]        sq_r_s2, sq_i_s2;
	logic [N_W-1:0]        ar_ext, ai_ext;

	// stage 3 at index 0, iteration stages after it
	logic                  vld_s  [ITERS+1];
	logic [N_W-1:0]        n_s    [ITERS+1];
	logic [REM_W-1:0]      rem_s  [ITERS+1];
	logic [MAG_W-1:0]      root_s [ITERS+1];
	logic signed [XW-1:0]  x_s    [ITERS+1];
	logic signed [XW-1:0]  y_s    [ITERS+1];
	logic signed [ZW-1:0]  z_s    [ITERS+1];
	logic                  zr_s   [ITERS+1];
	logic                  zi_s   [ITERS+1];
	quad_t                 quad_s [ITERS+1];

	// finishing stage
	logic                  vld_sf;
	logic [MAG_W-1:0]      root_sf;
	logic                  inc_sf;
	logic [ZC_W-1:0]       zc_sf;
	logic                  zr_sf, zi_sf;
	quad_t                 quad_sf;
	logic [ZC_W-1:0]       zc_c;
	logic [ZC_W:0]         ang_rnd;
	logic [ANG_W-1:0]      ang_c;

	assign adv          = !result_valid || !result_stall;
	assign sample_stall = !adv;

	always_comb begin
		ar_c = real_in[DATA_WIDTH-1] ? DATA_WIDTH'(-real_in) : DATA_WIDTH'(real_in);
		ai_c = imag_in[DATA_WIDTH-1] ? DATA_WIDTH'(-imag_in) : DATA_WIDTH'(imag_in);
		quad_c = QUAD_NONE;
		if (|real_in && |imag_in) begin
			case ({real_in[DATA_WIDTH-1], imag_in[DATA_WIDTH-1]})
				2'b00: quad_c = QUAD_1;
				2'b10: quad_c = QUAD_2;
				2'b11: quad_c = QUAD_3;
				2'b01: quad_c = QUAD_4;
				default: quad_c = QUAD_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sample_valid;
			vld_s2 <= vld_s1;
			vld_s[0] <= vld_s2;
		end
	end

	assign ar_ext = N_W'(ar_s1);
	assign ai_ext = N_W'(ai_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			ar_s1   <= ar_c;
			ai_s1   <= ai_c;
			zr_s1   <= ~|real_in;
			zi_s1   <= ~|imag_in;
			quad_s1 <= quad_c;

			ar_s2   <= ar_s1;
			ai_s2   <= ai_s1;
			zr_s2   <= zr_s1;
			zi_s2   <= zi_s1;
			quad_s2 <= quad_s1;
			sq_r_s2 <= ar_ext * ar_ext;
			sq_i_s2 <= ai_ext * ai_ext;

			n_s[0]    <= sq_r_s2 + sq_i_s2;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			x_s[0]    <= $signed({2'b00, ar_s2, {GUARD_BITS{1'b0}}});
			y_s[0]    <= $signed({2'b00, ai_s2, {GUARD_BITS{1'b0}}});
			z_s[0]    <= '0;
			zr_s[0]   <= zr_s2;
			zi_s[0]   <= zi_s2;
			quad_s[0] <= quad_s2;
		end
	end

	for (genvar j = 0; j < ITERS; j++) begin : g_it
		logic [REM_W-1:0]     rem_nx;
		logic [MAG_W-1:0]     root_nx;
		logic signed [XW-1:0] x_nx, y_nx;
		logic signed [ZW-1:0] z_nx;

		if (j < SQ_ITERS) begin : g_sq
			localparam int K = SQ_ITERS - 1 - j;
			logic [1:0]       pair;
			logic [REM_W-1:0] rem_sh, trial;

			if (K >= FRAC_BITS) begin : g_pair
				assign pair = n_s[j][2*(K-FRAC_BITS) +: 2];
			end else begin : g_zero
				assign pair = 2'b00;
			end

			always_comb begin
				rem_sh = {rem_s[j][REM_W-3:0], pair};
				trial  = {root_s[j], 2'b01};
				if (rem_sh >= trial) begin
					rem_nx  = rem_sh - trial;
					root_nx = {root_s[j][MAG_W-2:0], 1'b1};
				end else begin
					rem_nx  = rem_sh;
					root_nx = {root_s[j][MAG_W-2:0], 1'b0};
				end
			end
		end else begin : g_sq_pass
			assign rem_nx  = rem_s[j];
			assign root_nx = root_s[j];
		end

		if (j < CORDIC_STEPS) begin : g_rot
			localparam logic signed [ZW-1:0] STEP = $signed(ZW'(ATAN_DEG[j]));
			logic signed [XW-1:0] dx, dy;

			always_comb begin
				dx = y_s[j] >>> j;
				dy = x_s[j] >>> j;
				if (!y_s[j][XW-1]) begin
					x_nx = x_s[j] + dx;
					y_nx = y_s[j] - dy;
					z_nx = z_s[j] + STEP;
				end else begin
					x_nx = x_s[j] - dx;
					y_nx = y_s[j] + dy;
					z_nx = z_s[j] - STEP;
				end
			end
		end else begin : g_rot_pass
			assign x_nx = x_s[j];
			assign y_nx = y_s[j];
			assign z_nx = z_s[j];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				n_s[j+1]    <= n_s[j];
				rem_s[j+1]  <= rem_nx;
				root_s[j+1] <= root_nx;
				x_s[j+1]    <= x_nx;
				y_s[j+1]    <= y_nx;
				z_s[j+1]    <= z_nx;
				zr_s[j+1]   <= zr_s[j];
				zi_s[j+1]   <= zi_s[j];
				quad_s[j+1] <= quad_s[j];
			end
		end
	end

	always_comb begin
		if (z_s[ITERS][ZW-1]) begin
			zc_c = '0;
		end else if (z_s[ITERS][ZW-2:0] > (ZW-1)'(ANGLE_TOP)) begin
			zc_c = ANGLE_TOP;
		end else begin
			zc_c = z_s[ITERS][ZC_W-1:0];
		end
	end

	assign ang_rnd = {1'b0, zc_sf} + ANG_HALF;

	always_comb begin
		if (zr_sf && zi_sf) begin
			ang_c = '0;
		end else if (zr_sf) begin
			ang_c = ANG_RIGHT;
		end else if (zi_sf) begin
			ang_c = '0;
		end else begin
			ang_c = ang_rnd[SH +: ANG_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf       <= 1'b0;
			result_valid <= 1'b0;
		end else if (adv) begin
			vld_sf       <= vld_s[ITERS];
			result_valid <= vld_sf;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			root_sf <= root_s[ITERS];
			inc_sf  <= rem_s[ITERS] > REM_W'(root_s[ITERS]);
			zc_sf   <= zc_c;
			zr_sf   <= zr_s[ITERS];
			zi_sf   <= zi_s[ITERS];
			quad_sf <= quad_s[ITERS];

			magnitude_out <= root_sf + MAG_W'(inc_sf);
			angle_out     <= ang_c;
			quadrant_out  <= quad_sf;
		end
	end

endmodule

// ----- src/rtpq_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the rectangular to polar converter and their binding.
module rtpq_checker
	import rtpq_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            sample_stall,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic [DATA_WIDTH+FRAC_BITS-1:0] magnitude_out,
	input logic [FRAC_BITS+6:0]            angle_out,
	input logic [2:0]                      quadrant_out
);

	localparam int ANG_W = FRAC_BITS + 7;
	localparam logic [ANG_W-1:0] ANG_RIGHT = ANG_W'(DEG_RIGHT) << FRAC_BITS;

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !result_valid)
		else $error("result valid right after reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(magnitude_out)
			&& $stable(angle_out) && $stable(quadrant_out))
		else $error("stalled result changed");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> sample_stall)
		else $error("item taken while output blocked");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> angle_out <= ANG_RIGHT)
		else $error("angle above right angle");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && magnitude_out == '0 |-> angle_out == '0
			&& quad_t'(quadrant_out) == QUAD_NONE)
		else $error("origin gives nonzero angle or quadrant");

endmodule

bind rect_to_polar_quadrant rtpq_checker #(
	.DATA_WIDTH(DATA_WIDTH),
	.FRAC_BITS (FRAC_BITS)
) u_rtpq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.magnitude_out(magnitude_out),
	.angle_out    (angle_out),
	.quadrant_out (quadrant_out)
);
